/* rtl/rts_pkg.sv */
package rts_pkg;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_IDLE_INIT = 4'd1,
    CMD_START     = 4'd2,
    CMD_TERMINATE = 4'd3,
    CMD_SLEEP     = 4'd4,
    CMD_WAIT_EVT  = 4'd5,
    CMD_NOTIFY    = 4'd6,
    CMD_WAIT_MTX  = 4'd7,
    CMD_RELEASE   = 4'd8,
    CMD_SW_DONE   = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    RS_READY = 2'd0,
    RS_SLEEP = 2'd1,
    RS_WAIT  = 2'd2,
    RS_TERM  = 2'd3
  } run_state_t;

  typedef enum logic [1:0] {
    WK_NONE  = 2'd0,
    WK_EVENT = 2'd1,
    WK_MUTEX = 2'd2,
    WK_NEVER = 2'd3
  } wait_kind_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_RLS   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RLS  = 3'd1,
    ST_SCAN = 3'd2,
    ST_DONE = 3'd3,
    ST_FIND = 3'd4,
    ST_WAKE = 3'd5
  } fsm_t;

  localparam logic [7:0]  IDLE_PRIORITY = 8'd1;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  typedef struct packed {
    logic       used;
    run_state_t rs;
    wait_kind_t wk;
    logic [15:0] aged;
    logic [7:0] own;
    logic [7:0] inh;
    logic [31:0] s_start;
    logic [31:0] s_len;
    logic [31:0] m_start;
    logic [31:0] m_limit;
    logic [31:0] pend;
    logic [31:0] await_ev;
  } slot_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now;
  } rot_ctl_t;

endpackage

/* rtl/rts_cell.sv */
module rts_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  rts_pkg::slot_t  load_val,
  input  logic            shift,
  input  rts_pkg::slot_t  shift_in,
  output rts_pkg::slot_t  q
);

  rts_pkg::slot_t q_r;
  rts_pkg::slot_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (load) begin
      q_nxt = load_val;
    end else if (shift) begin
      q_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.used <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/rts_scan_step.sv */
module rts_scan_step (
  input  rts_pkg::slot_t   cur,
  input  rts_pkg::rot_ctl_t ctl,
  output rts_pkg::slot_t   upd,
  output logic             cand
);

  logic [31:0] sdiff;
  logic [31:0] mdiff;

  always_comb begin
    upd   = cur;
    cand  = 1'b0;
    sdiff = ctl.now - cur.s_start;
    mdiff = ctl.now - cur.m_start;
    if (cur.used && ctl.op == rts_pkg::OP_SCAN) begin
      unique case (cur.rs)
        rts_pkg::RS_READY: cand = 1'b1;
        rts_pkg::RS_TERM:  upd.used = 1'b0;
        rts_pkg::RS_SLEEP: begin
          if (sdiff >= cur.s_len) begin
            upd.rs      = rts_pkg::RS_READY;
            upd.s_start = '0;
            upd.s_len   = '0;
            cand        = 1'b1;
          end
        end
        default: begin
          if (cur.wk == rts_pkg::WK_MUTEX) begin
            if (cur.m_limit != 32'd0 && mdiff >= cur.m_limit) begin
              upd.rs      = rts_pkg::RS_READY;
              upd.wk      = rts_pkg::WK_NONE;
              upd.m_start = '0;
              upd.m_limit = '0;
              upd.inh     = '0;
              cand        = 1'b1;
            end
          end else if (cur.wk == rts_pkg::WK_EVENT) begin
            if ((cur.pend & cur.await_ev) == cur.await_ev) begin
              upd.rs       = rts_pkg::RS_READY;
              upd.wk       = rts_pkg::WK_NONE;
              upd.pend     = cur.pend & ~cur.await_ev;
              upd.await_ev = '0;
              cand         = 1'b1;
            end
          end
        end
      endcase
      if (cur.rs != rts_pkg::RS_TERM && cur.aged != rts_pkg::AGE_MAX) begin
        upd.aged = cur.aged + 16'd1;
      end
    end else if (cur.used && ctl.op == rts_pkg::OP_RLS) begin
      cand = (cur.rs == rts_pkg::RS_WAIT) && (cur.wk == rts_pkg::WK_MUTEX);
    end
  end

endmodule

/* rtl/rtos_thread_scheduler_unit.sv */
// Thread scheduler. Thread slots sit in a ring of cells that rotates by one
// slot per cycle while a lap runs. A scan (tick, sleep, waits, a release that
// wakes a waiter, terminate of the active thread) is one lap of the ring and
// a step that reloads the winner and queues it unless it is already running.
// A release first runs a lap of the ring to find the waiter and a step to wake
// it. Each command also passes through decode and a result state; a release
// that finds no waiter ends after the wake step, and start, idle_init, notify,
// switch_done, idle terminate and commands with nothing to do go straight
// from decode to the result. busy is high while a command runs; out_valid
// pulses for one cycle with the result, which must be taken then.
module rtos_thread_scheduler_unit #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [2:0]  in_target_slot,
  input  logic [7:0]  in_base_priority,
  input  logic [31:0] in_sleep_ticks,
  input  logic [31:0] in_event_bits,
  input  logic [31:0] in_mutex_wait_limit,
  input  logic        in_holder_present,
  input  logic [2:0]  in_holder_slot,
  output logic        out_valid,
  output logic        out_status,
  output logic        out_switch_request,
  output logic [2:0]  out_next_slot,
  output logic [2:0]  out_assigned_slot,
  output logic        out_running_valid,
  output logic [2:0]  out_running_slot
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  rts_pkg::slot_t cell_q   [NUM_SLOTS];
  rts_pkg::slot_t cell_ld  [NUM_SLOTS];
  logic           cell_lde [NUM_SLOTS];
  rts_pkg::slot_t head_upd;
  logic           head_cand;
  logic           shift;

  rts_pkg::fsm_t  st_r, st_nxt;
  rts_pkg::rot_ctl_t ctl;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [31:0]    now_r, now_nxt;
  logic           act_v_r, act_v_nxt;
  logic [SW-1:0]  act_r, act_nxt;
  logic           que_v_r, que_v_nxt;
  logic [SW-1:0]  que_r, que_nxt;
  logic           have_r, have_nxt;
  logic [15:0]    best_r, best_nxt;
  logic [SW-1:0]  top_r, top_nxt;
  logic           st_bad_r, st_bad_nxt;
  logic           sw_r, sw_nxt;
  logic [SW-1:0]  asg_r, asg_nxt;

  logic [SW-1:0]  free_idx;
  logic           free_ok;
  logic           act_ok, tgt_ok, hld_ok;
  logic [SW-1:0]  tgt_i, hld_i;
  logic [SW-1:0]  head_idx;
  logic [SW-1:0]  slot_sel [NUM_SLOTS];
  rts_pkg::slot_t fresh;
  logic           accept;
  logic           is_last;

  assign accept   = start && !busy;
  assign busy     = st_r != rts_pkg::ST_IDLE;
  assign head_idx = cnt_r[SW-1:0];
  assign is_last  = cnt_r == CW'(NUM_SLOTS - 1);
  assign ctl.op   = (st_r == rts_pkg::ST_SCAN) ? rts_pkg::OP_SCAN :
                    (st_r == rts_pkg::ST_FIND) ? rts_pkg::OP_RLS : rts_pkg::OP_NONE;
  assign ctl.now  = now_r;
  assign shift    = st_r == rts_pkg::ST_SCAN || st_r == rts_pkg::ST_FIND;

  assign tgt_i  = SW'(in_target_slot);
  assign hld_i  = SW'(in_holder_slot);
  assign tgt_ok = 32'(in_target_slot) < NUM_SLOTS && cell_q[tgt_i].used;
  assign hld_ok = 32'(in_holder_slot) < NUM_SLOTS && cell_q[hld_i].used;
  assign act_ok = act_v_r && cell_q[act_r].used;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!cell_q[i].used) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    fresh          = '0;
    fresh.used     = 1'b1;
    fresh.rs       = rts_pkg::RS_READY;
    fresh.wk       = rts_pkg::WK_NONE;
    fresh.own      = (in_command == rts_pkg::CMD_IDLE_INIT) ? rts_pkg::IDLE_PRIORITY
                                                            : in_base_priority;
    fresh.aged     = {8'd0, fresh.own};
  end

  rts_scan_step u_step (
    .cur  (cell_q[0]),
    .ctl  (ctl),
    .upd  (head_upd),
    .cand (head_cand)
  );

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cell_ld[i]  = cell_q[i];
      cell_lde[i] = 1'b0;
      slot_sel[i] = SW'(i);
    end
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    act_v_nxt      = act_v_r;
    act_nxt        = act_r;
    que_v_nxt      = que_v_r;
    que_nxt        = que_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    top_nxt        = top_r;
    st_bad_nxt     = st_bad_r;
    sw_nxt         = sw_r;
    asg_nxt        = asg_r;
    unique case (st_r)
      rts_pkg::ST_IDLE: begin
        if (accept) begin
          st_nxt     = rts_pkg::ST_DONE;
          cnt_nxt    = '0;
          have_nxt   = 1'b0;
          best_nxt   = '0;
          top_nxt    = '0;
          st_bad_nxt = 1'b0;
          sw_nxt     = 1'b0;
          asg_nxt    = '0;
          unique case (in_command)
            rts_pkg::CMD_TICK: begin
              now_nxt = now_r + 32'd1;
              st_nxt  = rts_pkg::ST_SCAN;
            end
            rts_pkg::CMD_IDLE_INIT, rts_pkg::CMD_START: begin
              if (free_ok) begin
                cell_ld[free_idx]  = fresh;
                cell_lde[free_idx] = 1'b1;
                asg_nxt            = free_idx;
                if (in_command == rts_pkg::CMD_IDLE_INIT) begin
                  act_v_nxt = 1'b1;
                  act_nxt   = free_idx;
                end
              end else begin
                st_bad_nxt = 1'b1;
              end
            end
            rts_pkg::CMD_TERMINATE: begin
              if (tgt_ok) begin
                cell_ld[tgt_i].rs  = rts_pkg::RS_TERM;
                cell_lde[tgt_i]    = 1'b1;
                if (act_v_r && act_r == tgt_i) st_nxt = rts_pkg::ST_SCAN;
              end
            end
            rts_pkg::CMD_SLEEP: begin
              if (act_ok) begin
                cell_ld[act_r].rs      = rts_pkg::RS_SLEEP;
                cell_ld[act_r].s_len   = in_sleep_ticks;
                cell_ld[act_r].s_start = now_r;
                cell_lde[act_r]        = 1'b1;
                st_nxt                 = rts_pkg::ST_SCAN;
              end
            end
            rts_pkg::CMD_WAIT_EVT: begin
              if (act_ok) begin
                cell_ld[act_r].rs       = rts_pkg::RS_WAIT;
                cell_ld[act_r].wk       = rts_pkg::WK_EVENT;
                cell_ld[act_r].await_ev = in_event_bits;
                cell_lde[act_r]         = 1'b1;
                st_nxt                  = rts_pkg::ST_SCAN;
              end
            end
            rts_pkg::CMD_NOTIFY: begin
              if (tgt_ok) begin
                cell_ld[tgt_i].pend = cell_q[tgt_i].pend | in_event_bits;
                cell_lde[tgt_i]     = 1'b1;
              end
            end
            rts_pkg::CMD_WAIT_MTX: begin
              if (act_ok) begin
                cell_ld[act_r].rs      = rts_pkg::RS_WAIT;
                cell_ld[act_r].wk      = rts_pkg::WK_MUTEX;
                cell_ld[act_r].m_limit = in_mutex_wait_limit;
                cell_ld[act_r].m_start = now_r;
                cell_lde[act_r]        = 1'b1;
                if (in_holder_present && hld_ok &&
                    cell_q[act_r].own > cell_q[hld_i].own &&
                    cell_q[act_r].own > cell_q[hld_i].inh) begin
                  cell_ld[hld_i].inh = cell_q[act_r].own;
                  cell_lde[hld_i]    = 1'b1;
                end
                st_nxt = rts_pkg::ST_SCAN;
              end
            end
            rts_pkg::CMD_RELEASE: begin
              if (act_ok) st_nxt = rts_pkg::ST_FIND;
            end
            rts_pkg::CMD_SW_DONE: begin
              if (que_v_r) begin
                act_v_nxt = 1'b1;
                act_nxt   = que_r;
                que_v_nxt = 1'b0;
                que_nxt   = '0;
              end
            end
            default: st_bad_nxt = 1'b1;
          endcase
        end
      end
      rts_pkg::ST_FIND: begin
        if (head_cand && {8'd0, cell_q[0].own} > best_r) begin
          best_nxt = {8'd0, cell_q[0].own};
          top_nxt  = head_idx;
          have_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (is_last) begin
          st_nxt  = rts_pkg::ST_WAKE;
          cnt_nxt = '0;
        end
      end
      rts_pkg::ST_WAKE: begin
        st_nxt   = rts_pkg::ST_DONE;
        have_nxt = 1'b0;
        best_nxt = '0;
        top_nxt  = '0;
        if (have_r) begin
          cell_ld[top_r].rs      = rts_pkg::RS_READY;
          cell_ld[top_r].wk      = rts_pkg::WK_NONE;
          cell_ld[top_r].m_start = '0;
          cell_ld[top_r].m_limit = '0;
          cell_ld[top_r].inh     = '0;
          cell_lde[top_r]        = 1'b1;
          st_nxt                 = rts_pkg::ST_SCAN;
        end
      end
      rts_pkg::ST_SCAN: begin
        if (head_cand && head_upd.aged != 16'd0 && cell_q[0].aged > best_r) begin
          best_nxt = cell_q[0].aged;
          top_nxt  = head_idx;
          have_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (is_last) begin
          st_nxt  = rts_pkg::ST_RLS;
          cnt_nxt = '0;
        end
      end
      rts_pkg::ST_RLS: begin
        st_nxt = rts_pkg::ST_DONE;
        if (have_r) begin
          if (!act_v_r || top_r != act_r) begin
            que_v_nxt = 1'b1;
            que_nxt   = top_r;
            sw_nxt    = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = rts_pkg::ST_IDLE;
      end
    endcase
  end

  // ring: head cell 0 feeds the last cell; a full lap restores slot order
  logic rls_reload;
  assign rls_reload = st_r == rts_pkg::ST_RLS && have_r;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      rts_pkg::slot_t sin;
      rts_pkg::slot_t ldv;
      logic           lde;
      logic           sh;
      always_comb begin
        sin = (g == NUM_SLOTS - 1) ? head_upd : cell_q[(g + 1) % NUM_SLOTS];
        ldv = cell_ld[g];
        lde = cell_lde[g];
        sh  = shift;
        if (rls_reload && top_r == slot_sel[g]) begin
          ldv      = cell_q[g];
          ldv.aged = (cell_q[g].inh != 8'd0) ? {8'd0, cell_q[g].inh}
                                             : {8'd0, cell_q[g].own};
          lde      = 1'b1;
        end
      end
      rts_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (lde),
        .load_val (ldv),
        .shift    (sh),
        .shift_in (sin),
        .q        (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= rts_pkg::ST_IDLE;
      cnt_r        <= '0;
      now_r        <= '0;
      act_v_r      <= 1'b0;
      act_r        <= '0;
      que_v_r      <= 1'b0;
      que_r        <= '0;
      have_r       <= 1'b0;
      best_r       <= '0;
      top_r        <= '0;
      st_bad_r     <= 1'b0;
      sw_r         <= 1'b0;
      asg_r        <= '0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      now_r        <= now_nxt;
      act_v_r      <= act_v_nxt;
      act_r        <= act_nxt;
      que_v_r      <= que_v_nxt;
      que_r        <= que_nxt;
      have_r       <= have_nxt;
      best_r       <= best_nxt;
      top_r        <= top_nxt;
      st_bad_r     <= st_bad_nxt;
      sw_r         <= sw_nxt;
      asg_r        <= asg_nxt;
    end
  end

  assign out_valid          = st_r == rts_pkg::ST_DONE;
  assign out_status         = st_bad_r;
  assign out_switch_request = sw_r;
  assign out_next_slot      = sw_r ? 3'(que_r) : 3'd0;
  assign out_assigned_slot  = 3'(asg_r);
  assign out_running_valid  = act_v_r;
  assign out_running_slot   = act_v_r ? 3'(act_r) : 3'd0;

endmodule

/* rtl/rts_checker.sv */
module rts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_switch_request,
  input logic       out_running_valid,
  input logic [2:0] out_next_slot,
  input logic [2:0] out_running_slot
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");

  a_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

  a_sw_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switch_request && out_running_valid) |->
    out_next_slot != out_running_slot) else $error("switch to running slot");

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running_valid) |-> out_running_slot == 3'd0)
    else $error("running slot without valid");

endmodule

bind rtos_thread_scheduler_unit rts_checker u_rts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_switch_request (out_switch_request),
  .out_running_valid  (out_running_valid),
  .out_next_slot      (out_next_slot),
  .out_running_slot   (out_running_slot)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int RANDOM_ITEMS = 1930;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [3:0] CMD_BAD_LO = rts_pkg::CMD_SW_DONE + 4'd1;
  localparam logic [3:0] CMD_BAD_HI = 4'hF;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  tgt;
    logic [7:0]  prio;
    logic [31:0] ticks;
    logic [31:0] bits;
    logic [31:0] lim;
    logic        hp;
    logic [2:0]  hs;
  } cmd_item_t;

  typedef struct packed {
    logic       status;
    logic       sw;
    logic [2:0] nxt;
    logic [2:0] asg;
    logic       rv;
    logic [2:0] rs;
  } sched_result_t;

  typedef struct packed {
    cmd_item_t     item;
    logic          typed;
    sched_result_t res;
  } table_row_t;

  logic clk, rst_n, start, busy;
  logic [3:0] in_command;
  logic [2:0] in_target_slot, in_holder_slot;
  logic [7:0] in_base_priority;
  logic [31:0] in_sleep_ticks, in_event_bits, in_mutex_wait_limit;
  logic in_holder_present;
  logic out_valid, out_status, out_switch_request, out_running_valid;
  logic [2:0] out_next_slot, out_assigned_slot, out_running_slot;

  rtos_thread_scheduler_unit #(.NUM_SLOTS(SLOTS)) dut (.*);

  // scheduler shadow state
  logic        used [SLOTS];
  rts_pkg::run_state_t rstate [SLOTS];
  rts_pkg::wait_kind_t wkind [SLOTS];
  logic [15:0] aged [SLOTS];
  logic [7:0]  own [SLOTS];
  logic [7:0]  inh [SLOTS];
  logic [31:0] s_start [SLOTS], s_len [SLOTS], m_start [SLOTS], m_limit [SLOTS];
  logic [31:0] pend [SLOTS], awaited [SLOTS];
  logic [31:0] now;
  logic        act_v, que_v;
  logic [2:0]  act, que;

  sched_result_t expected_results [$];
  int fails, cycles, items_sent, switches_seen, full_seen;

  function automatic void clear_mutex(int i);
    rstate[i] = rts_pkg::RS_READY;
    wkind[i] = rts_pkg::WK_NONE;
    m_start[i] = '0;
    m_limit[i] = '0;
    inh[i] = '0;
  endfunction

  function automatic logic pick_next();
    logic [31:0] best;
    logic have, cand;
    int top;
    best = '0;
    have = 1'b0;
    top = 0;
    for (int i = 0; i < SLOTS; i++) begin
      cand = 1'b0;
      if (!used[i]) continue;
      unique case (rstate[i])
        rts_pkg::RS_READY: cand = 1'b1;
        rts_pkg::RS_TERM: begin
          used[i] = 1'b0;
          continue;
        end
        rts_pkg::RS_SLEEP: begin
          if (now - s_start[i] >= s_len[i]) begin
            rstate[i] = rts_pkg::RS_READY;
            s_start[i] = '0;
            s_len[i] = '0;
            cand = 1'b1;
          end
        end
        default: begin
          if (wkind[i] == rts_pkg::WK_MUTEX) begin
            if (m_limit[i] != 0 && now - m_start[i] >= m_limit[i]) begin
              clear_mutex(i);
              cand = 1'b1;
            end
          end else if (wkind[i] == rts_pkg::WK_EVENT) begin
            if ((pend[i] & awaited[i]) == awaited[i]) begin
              rstate[i] = rts_pkg::RS_READY;
              wkind[i] = rts_pkg::WK_NONE;
              pend[i] &= ~awaited[i];
              awaited[i] = '0;
              cand = 1'b1;
            end
          end
        end
      endcase
      if (cand && {16'd0, aged[i]} > best) begin
        best = {16'd0, aged[i]};
        top = i;
        have = 1'b1;
      end
      if (aged[i] != rts_pkg::AGE_MAX) aged[i]++;
    end
    if (!have) return 1'b0;
    aged[top] = (inh[top] != 0) ? {8'd0, inh[top]} : {8'd0, own[top]};
    if (!act_v || top != 32'(act)) begin
      que_v = 1'b1;
      que = top[2:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic claim_slot(logic [7:0] p, output logic [2:0] where);
    where = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!used[i]) begin
        used[i] = 1'b1;
        rstate[i] = rts_pkg::RS_READY;
        wkind[i] = rts_pkg::WK_NONE;
        own[i] = p;
        aged[i] = {8'd0, p};
        inh[i] = '0;
        s_start[i] = '0;
        s_len[i] = '0;
        m_start[i] = '0;
        m_limit[i] = '0;
        pend[i] = '0;
        awaited[i] = '0;
        where = i[2:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_step(cmd_item_t c);
    sched_result_t r;
    logic act_ok, sw, found;
    logic [2:0] a, asg;
    logic [7:0] best;
    int pick;
    r = '0;
    sw = 1'b0;
    asg = '0;
    act_ok = act_v && used[act];
    a = act_ok ? act : 3'd0;
    unique case (c.cmd)
      rts_pkg::CMD_TICK: begin
        now++;
        sw = pick_next();
      end
      rts_pkg::CMD_IDLE_INIT: begin
        if (claim_slot(rts_pkg::IDLE_PRIORITY, asg)) begin
          act_v = 1'b1;
          act = asg;
        end else r.status = 1'b1;
      end
      rts_pkg::CMD_START: if (!claim_slot(c.prio, asg)) r.status = 1'b1;
      rts_pkg::CMD_TERMINATE: begin
        if (used[c.tgt]) begin
          rstate[c.tgt] = rts_pkg::RS_TERM;
          if (act_v && act == c.tgt) sw = pick_next();
        end
      end
      rts_pkg::CMD_SLEEP: begin
        if (act_ok) begin
          rstate[a] = rts_pkg::RS_SLEEP;
          s_len[a] = c.ticks;
          s_start[a] = now;
          sw = pick_next();
        end
      end
      rts_pkg::CMD_WAIT_EVT: begin
        if (act_ok) begin
          rstate[a] = rts_pkg::RS_WAIT;
          wkind[a] = rts_pkg::WK_EVENT;
          awaited[a] = c.bits;
          sw = pick_next();
        end
      end
      rts_pkg::CMD_NOTIFY: if (used[c.tgt]) pend[c.tgt] |= c.bits;
      rts_pkg::CMD_WAIT_MTX: begin
        if (act_ok) begin
          rstate[a] = rts_pkg::RS_WAIT;
          wkind[a] = rts_pkg::WK_MUTEX;
          m_limit[a] = c.lim;
          m_start[a] = now;
          if (c.hp && used[c.hs] && own[a] > own[c.hs] && own[a] > inh[c.hs])
            inh[c.hs] = own[a];
          sw = pick_next();
        end
      end
      rts_pkg::CMD_RELEASE: begin
        if (act_ok) begin
          best = '0;
          pick = 0;
          found = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (used[i] && rstate[i] == rts_pkg::RS_WAIT &&
                wkind[i] == rts_pkg::WK_MUTEX && own[i] > best) begin
              best = own[i];
              pick = i;
              found = 1'b1;
            end
          end
          if (found) begin
            clear_mutex(pick);
            sw = pick_next();
          end
        end
      end
      rts_pkg::CMD_SW_DONE: begin
        if (que_v) begin
          act_v = 1'b1;
          act = que;
          que_v = 1'b0;
          que = '0;
        end
      end
      default: r.status = 1'b1;
    endcase
    r.sw = sw;
    r.nxt = sw ? que : 3'd0;
    r.asg = asg;
    r.rv = act_v;
    r.rs = act_v ? act : 3'd0;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic check_field(string name, logic [2:0] exp, logic [2:0] got);
    if (exp !== got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", 3'(e.status), 3'(out_status));
        check_field("switch_request", 3'(e.sw), 3'(out_switch_request));
        check_field("next_slot", e.nxt, out_next_slot);
        check_field("assigned_slot", e.asg, out_assigned_slot);
        check_field("running_valid", 3'(e.rv), 3'(out_running_valid));
        check_field("running_slot", e.rs, out_running_slot);
        if (out_switch_request === 1'b1) switches_seen++;
        if (out_status === 1'b1) full_seen++;
      end
    end
  end

  task automatic send(cmd_item_t c, int gap, logic typed, sched_result_t exp);
    sched_result_t p;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    {in_command, in_target_slot, in_base_priority, in_sleep_ticks, in_event_bits,
     in_mutex_wait_limit, in_holder_present, in_holder_slot} = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    p = schedule_step(c);
    expected_results.push_back(typed ? exp : p);
    items_sent++;
  endtask

  function automatic cmd_item_t mk(logic [3:0] cmd, logic [2:0] tgt, logic [7:0] prio,
                                   logic [31:0] ticks, logic [31:0] bits, logic [31:0] lim,
                                   logic hp, logic [2:0] hs);
    return {cmd, tgt, prio, ticks, bits, lim, hp, hs};
  endfunction

  function automatic logic [31:0] small_or_wide(int hi);
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, hi);
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t c;
    int any_used, r;
    any_used = 0;
    for (int i = 0; i < SLOTS; i++) any_used += int'(used[i]);
    c = '0;
    c.tgt = 3'($urandom);
    c.prio = 8'($urandom);
    c.hp = 1'($urandom);
    c.hs = 3'($urandom);
    r = $urandom_range(0, 99);
    if (any_used == 0 && r < 70) c.cmd = rts_pkg::CMD_IDLE_INIT;
    else if (r < 25) c.cmd = rts_pkg::CMD_TICK;
    else if (r < 33) c.cmd = rts_pkg::CMD_START;
    else if (r < 35) c.cmd = rts_pkg::CMD_IDLE_INIT;
    else if (r < 41) c.cmd = rts_pkg::CMD_TERMINATE;
    else if (r < 50) c.cmd = rts_pkg::CMD_SLEEP;
    else if (r < 58) c.cmd = rts_pkg::CMD_WAIT_EVT;
    else if (r < 67) c.cmd = rts_pkg::CMD_NOTIFY;
    else if (r < 75) c.cmd = rts_pkg::CMD_WAIT_MTX;
    else if (r < 83) c.cmd = rts_pkg::CMD_RELEASE;
    else if (r < 98) c.cmd = rts_pkg::CMD_SW_DONE;
    else c.cmd = 4'($urandom_range(32'(CMD_BAD_LO), 32'(CMD_BAD_HI)));
    c.ticks = small_or_wide(6);
    c.bits = small_or_wide(15);
    c.lim = small_or_wide(6);
    return c;
  endfunction

  table_row_t directed [$];

  initial begin
    sched_result_t none;
    int gap;
    logic burst;
    none = '0;
    start = 1'b0;
    {in_command, in_target_slot, in_base_priority, in_sleep_ticks, in_event_bits,
     in_mutex_wait_limit, in_holder_present, in_holder_slot} = '0;
    fails = 0;
    cycles = 0;
    items_sent = 0;
    switches_seen = 0;
    full_seen = 0;
    for (int i = 0; i < SLOTS; i++) begin
      used[i] = 1'b0;
      rstate[i] = rts_pkg::RS_READY;
      wkind[i] = rts_pkg::WK_NONE;
      aged[i] = '0;
      own[i] = '0;
      inh[i] = '0;
      s_start[i] = '0;
      s_len[i] = '0;
      m_start[i] = '0;
      m_limit[i] = '0;
      pend[i] = '0;
      awaited[i] = '0;
    end
    now = '0;
    act_v = 1'b0;
    act = '0;
    que_v = 1'b0;
    que = '0;

    directed.push_back({mk(rts_pkg::CMD_SW_DONE, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    directed.push_back({mk(CMD_BAD_HI, 7, 8'hFF, '1, '1, '1, 1, 7), 1'b1,
                        sched_result_t'({1'b1, 11'd0})});
    directed.push_back({mk(rts_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    directed.push_back({mk(rts_pkg::CMD_SLEEP, 0, 0, 5, 0, 0, 0, 0), 1'b1, none});
    directed.push_back({mk(rts_pkg::CMD_IDLE_INIT, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        sched_result_t'({1'b0, 1'b0, 3'd0, 3'd0, 1'b1, 3'd0})});
    directed.push_back({mk(rts_pkg::CMD_START, 0, 8'hFF, 0, 0, 0, 0, 0), 1'b1,
                        sched_result_t'({1'b0, 1'b0, 3'd0, 3'd1, 1'b1, 3'd0})});
    directed.push_back({mk(rts_pkg::CMD_START, 0, 8'h00, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_NOTIFY, 7, 0, 0, '1, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_SW_DONE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_START, 0, 8'd200, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_WAIT_MTX, 0, 0, 0, 0, 0, 1, 3), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_SW_DONE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_WAIT_EVT, 0, 0, 0, '1, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_NOTIFY, 3, 0, 0, '1, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_RELEASE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_SW_DONE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_SLEEP, 0, 0, '1, 0, 0, 0, 0), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_WAIT_MTX, 0, 0, 0, 0, '1, 1, 7), 1'b0, none});
    directed.push_back({mk(rts_pkg::CMD_TERMINATE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    for (int i = 0; i < 4; i++)
      directed.push_back({mk(rts_pkg::CMD_START, 0, 8'(8'h80 + i), 0, 0, 0, 0, 0),
                          1'b0, none});

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[k])
      send(directed[k].item, $urandom_range(0, 2), directed[k].typed, directed[k].res);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 11);
      send(random_item(), gap, 1'b0, none);
    end
    @(negedge clk);
    start = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);
    $display("%0d commands issued, %0d switch requests and %0d invalid statuses checked",
             items_sent, switches_seen, full_seen);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
rtl/rts_pkg.sv
rtl/rts_cell.sv
rtl/rts_scan_step.sv
rtl/rtos_thread_scheduler_unit.sv
rtl/rts_checker.sv
tb/tb.sv
